### hdl/u8u16_pkg.sv
package u8u16_pkg;

  localparam int QueueDepth = 4;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  localparam logic [15:0] UNIT_REPLACE = 16'hfffd;
  localparam logic [20:0] CP_MAX = 21'h10ffff;
  localparam logic [20:0] CP_SUR_LO = 21'h00d800;
  localparam logic [20:0] CP_SUR_HI = 21'h00dfff;
  localparam logic [20:0] CP_BMP_MAX = 21'h00ffff;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [15:0] UNIT_HI_SUR = 16'hd800;
  localparam logic [15:0] UNIT_LO_SUR = 16'hdc00;

  // One queue entry: rep_cnt replacement units first, then tail_cnt tail units.
  typedef struct packed {
    logic [1:0]  rep_cnt;
    logic [1:0]  tail_cnt;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        term;
  } entry_t;

endpackage

### hdl/u8u16_front.sv
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  output logic       push,
  output entry_t     entry
);

  logic [20:0] partial_value;
  logic [1:0]  bytes_expected;
  logic [1:0]  bytes_taken;
  logic [20:0] partial_value_next;
  logic [1:0]  bytes_expected_next;
  logic [1:0]  bytes_taken_next;

  logic [20:0] cp_acc;
  logic [1:0]  taken_inc;
  logic [20:0] cp_off;
  logic        is_cont;
  logic        fresh;

  always_comb begin
    is_cont   = (data_byte[7:6] == 2'b10);
    cp_acc    = {partial_value[14:0], data_byte[5:0]};
    taken_inc = bytes_taken + 2'd1;
    cp_off    = cp_acc - CP_SUPP_BASE;
    fresh     = 1'b0;

    partial_value_next  = partial_value;
    bytes_expected_next = bytes_expected;
    bytes_taken_next    = bytes_taken;
    entry               = '0;

    if (bytes_expected != 2'd0) begin
      if (is_cont) begin
        if (taken_inc >= bytes_expected) begin
          partial_value_next  = '0;
          bytes_expected_next = '0;
          bytes_taken_next    = '0;
          if (cp_acc > CP_MAX || (cp_acc >= CP_SUR_LO && cp_acc <= CP_SUR_HI)) begin
            entry.tail_cnt = 2'd1;
            entry.unit0    = UNIT_REPLACE;
          end else if (cp_acc > CP_BMP_MAX) begin
            entry.tail_cnt = 2'd2;
            entry.unit0    = UNIT_HI_SUR | {6'd0, cp_off[19:10]};
            entry.unit1    = UNIT_LO_SUR | {6'd0, cp_off[9:0]};
          end else begin
            entry.tail_cnt = 2'd1;
            entry.unit0    = cp_acc[15:0];
          end
        end else begin
          partial_value_next = cp_acc;
          bytes_taken_next   = taken_inc;
        end
      end else begin
        // broken sequence: lead plus taken continuations, then rehandle byte
        entry.rep_cnt       = taken_inc;
        partial_value_next  = '0;
        bytes_expected_next = '0;
        bytes_taken_next    = '0;
        fresh               = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (data_byte == 8'd0) begin
        entry.tail_cnt = 2'd1;
        entry.unit0    = '0;
        entry.term     = 1'b1;
      end else if (data_byte[7] == 1'b0) begin
        entry.tail_cnt = 2'd1;
        entry.unit0    = {8'd0, data_byte};
      end else if (data_byte[7:5] == 3'b110) begin
        partial_value_next  = {16'd0, data_byte[4:0]};
        bytes_expected_next = 2'd1;
        bytes_taken_next    = '0;
      end else if (data_byte[7:4] == 4'b1110) begin
        partial_value_next  = {17'd0, data_byte[3:0]};
        bytes_expected_next = 2'd2;
        bytes_taken_next    = '0;
      end else if (data_byte[7:3] == 5'b11110) begin
        partial_value_next  = {18'd0, data_byte[2:0]};
        bytes_expected_next = 2'd3;
        bytes_taken_next    = '0;
      end else begin
        entry.tail_cnt = 2'd1;
        entry.unit0    = UNIT_REPLACE;
      end
    end

    push = take && ((entry.rep_cnt != 2'd0) || (entry.tail_cnt != 2'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value  <= '0;
      bytes_expected <= '0;
      bytes_taken    <= '0;
    end else if (take) begin
      partial_value  <= partial_value_next;
      bytes_expected <= bytes_expected_next;
      bytes_taken    <= bytes_taken_next;
    end
  end

endmodule

### hdl/u8u16_fifo.sv
module u8u16_fifo
  import u8u16_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t head
);

  entry_t            slots [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;

  assign full      = (count == QCntW'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/u8u16_back.sv
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        is_terminator,
  output logic        last_of_run
);

  logic [1:0]  idx;
  logic [2:0]  total;
  logic [1:0]  tail_idx;
  logic        emit;
  logic        in_tail;
  logic        is_last;
  logic [15:0] unit_sel;

  always_comb begin
    total    = {1'b0, head.rep_cnt} + {1'b0, head.tail_cnt};
    in_tail  = (idx >= head.rep_cnt);
    tail_idx = idx - head.rep_cnt;
    if (!in_tail) begin
      unit_sel = UNIT_REPLACE;
    end else if (tail_idx == 2'd0) begin
      unit_sel = head.unit0;
    end else begin
      unit_sel = head.unit1;
    end
    is_last = (({1'b0, idx} + 3'd1) == total);
    emit    = head_valid && (!out_valid || out_ready);
    pop     = emit && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        idx       <= is_last ? 2'd0 : idx + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_unit     <= unit_sel;
      is_terminator <= head.term && in_tail;
      last_of_run   <= is_last;
    end
  end

endmodule

### hdl/utf8_to_utf16_transcoder.sv
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------------
// input   | in_valid / in_ready  | data_byte[7:0]
// output  | out_valid / out_ready| code_unit[15:0], is_terminator, last_of_run
//
// One byte per cycle is taken while the entry queue has room; the front
// decodes it in the same cycle and queues one entry per byte that yields units.
// The back emits one unit per cycle, unless out_ready stalls it, from the queue
// head through an output register.
// Sync active-high rst clears decode state, queue pointers and out_valid.
// A stalled output fills the 4-entry queue, then in_ready drops.
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        is_terminator,
  output logic        last_of_run
);

  logic   q_full;
  logic   q_not_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;

  // input transaction completes whenever the queue has a free slot
  assign in_ready = !q_full;

  u8u16_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (in_valid && in_ready),
    .data_byte (data_byte),
    .push      (push),
    .entry     (push_entry)
  );

  u8u16_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  u8u16_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_not_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .code_unit     (code_unit),
    .is_terminator (is_terminator),
    .last_of_run   (last_of_run)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import u8u16_pkg::*;

  localparam int StimBytes = 160;
  localparam int MaxWait = 16;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 16;

  // Expected UTF-16 output units, predicted per accepted input byte.
  class utf16_unit_board;
    logic [15:0] pending_unit[$];
    bit          pending_term[$];
    bit          pending_last[$];
    int unsigned mismatch_cnt;

    // decoder state
    logic [20:0] partial;
    logic [1:0]  need;
    logic [1:0]  taken;

    // units caused by the byte being predicted
    logic [15:0] run_unit[4];
    bit          run_term[4];
    int          run_cnt;

    function new();
      mismatch_cnt = 0;
      partial = '0;
      need = '0;
      taken = '0;
      run_cnt = 0;
    endfunction

    function int pending();
      return pending_unit.size();
    endfunction

    function void add_unit(logic [15:0] u, bit t);
      if (run_cnt < 4) begin
        run_unit[run_cnt] = u;
        run_term[run_cnt] = t;
        run_cnt++;
      end
    endfunction

    function void add_code_point(logic [20:0] cp);
      logic [19:0] v;
      if (cp > CP_MAX || (cp >= CP_SUR_LO && cp <= CP_SUR_HI))
        cp = {5'd0, UNIT_REPLACE};
      if (cp > CP_BMP_MAX) begin
        v = 20'(cp - CP_SUPP_BASE);
        add_unit(UNIT_HI_SUR | {6'd0, v[19:10]}, 1'b0);
        add_unit(UNIT_LO_SUR | {6'd0, v[9:0]}, 1'b0);
      end else begin
        add_unit(cp[15:0], 1'b0);
      end
    endfunction

    function void close_seq();
      partial = '0;
      need = '0;
      taken = '0;
    endfunction

    // Byte seen with no sequence open.
    function void start_byte(logic [7:0] b);
      if (b == 8'h00) begin
        add_unit(16'h0000, 1'b1);
      end else if (b[7] == 1'b0) begin
        add_unit({8'h00, b}, 1'b0);
      end else if (b[7:5] == 3'b110) begin
        partial = {16'd0, b[4:0]};
        need = 2'd1;
        taken = 2'd0;
      end else if (b[7:4] == 4'b1110) begin
        partial = {17'd0, b[3:0]};
        need = 2'd2;
        taken = 2'd0;
      end else if (b[7:3] == 5'b11110) begin
        partial = {18'd0, b[2:0]};
        need = 2'd3;
        taken = 2'd0;
      end else begin
        add_unit(UNIT_REPLACE, 1'b0);   // stray continuation or 0xF8..0xFF
      end
    endfunction

    function void take_byte(logic [7:0] b);
      run_cnt = 0;
      if (need != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          partial = {partial[14:0], b[5:0]};
          taken = taken + 2'd1;
          if (taken >= need) begin
            add_code_point(partial);
            close_seq();
          end
        end else begin
          // broken sequence: one replacement for the lead and per continuation
          for (int i = 0; i <= int'(taken); i++)
            add_unit(UNIT_REPLACE, 1'b0);
          close_seq();
          start_byte(b);
        end
      end else begin
        start_byte(b);
      end
      for (int i = 0; i < run_cnt; i++) begin
        pending_unit.push_back(run_unit[i]);
        pending_term.push_back(run_term[i]);
        pending_last.push_back(i == run_cnt - 1);
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_cnt++;
    endtask

    task match_unit(logic [15:0] u, logic t, logic l);
      logic [15:0] eu;
      bit          et;
      bit          el;
      if (pending_unit.size() == 0) begin
        report_mismatch($sformatf("unexpected unit %h term %b last %b", u, t, l));
      end else begin
        eu = pending_unit.pop_front();
        et = pending_term.pop_front();
        el = pending_last.pop_front();
        if (u !== eu)
          report_mismatch($sformatf("code_unit %h, expected %h", u, eu));
        if (t !== et)
          report_mismatch($sformatf("is_terminator %b, expected %b (unit %h)", t, et, eu));
        if (l !== el)
          report_mismatch($sformatf("last_of_run %b, expected %b (unit %h)", l, el, eu));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] code_unit;
  logic        is_terminator;
  logic        last_of_run;

  int unsigned     cycle_cnt = 0;
  logic [7:0]      byte_stream[$];
  utf16_unit_board board;

  utf8_to_utf16_transcoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_unit    (code_unit),
    .is_terminator(is_terminator),
    .last_of_run  (last_of_run)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Wait per transaction: every third stretch of 32 runs with no gaps.
  function automatic int draw_wait(int idx);
    if ((idx / 32) % 3 == 1)
      return 0;
    if ($urandom_range(0, 2) == 0)
      return 0;
    return $urandom_range(0, MaxWait);
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Lead byte for a sequence of len bytes, random payload bits.
  function automatic logic [7:0] lead_byte(int len);
    case (len)
      1: return 8'($urandom_range(1, 127));
      2: return 8'hc0 | 8'($urandom_range(0, 31));
      3: return 8'he0 | 8'($urandom_range(0, 15));
      default: return 8'hf0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic build_stream();
    logic [7:0] directed[] = '{
      8'h41,                          // plain ASCII
      8'hc2, 8'ha9,                   // two-byte form
      8'he2, 8'h82, 8'hac,            // three-byte form
      8'hf4, 8'h8f, 8'hbf, 8'hbf,     // highest code point, surrogate pair
      8'hed, 8'ha0, 8'h80,            // encoded surrogate -> replacement
      8'hf7, 8'hbf, 8'hbf, 8'hbf,     // above the code point range
      8'hc0, 8'h80,                   // overlong NUL, decoded as zero unit
      8'hff, 8'h80,                   // bad lead, then stray continuation
      8'hf0, 8'h9f, 8'h98, 8'h41,     // sequence broken after two continuations
      8'he2, 8'h00,                   // terminator inside a sequence
      8'h7f, 8'h00                    // highest ASCII, then end of string
    };
    int kind;
    int len;
    int keep;
    logic [7:0] b;
    foreach (directed[i])
      byte_stream.push_back(directed[i]);
    while (byte_stream.size() < StimBytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        len = $urandom_range(1, 4);
        byte_stream.push_back(lead_byte(len));
        for (int i = 1; i < len; i++)
          byte_stream.push_back(cont_byte());
      end else if (kind < 78) begin
        byte_stream.push_back(8'h00);
      end else if (kind < 88) begin
        // truncated sequence followed by a non-continuation byte
        len = $urandom_range(2, 4);
        keep = $urandom_range(0, len - 2);
        byte_stream.push_back(lead_byte(len));
        for (int i = 0; i < keep; i++)
          byte_stream.push_back(cont_byte());
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10)
          b = b ^ 8'h40;
        byte_stream.push_back(b);
      end else begin
        byte_stream.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic send_bytes();
    int gap;
    foreach (byte_stream[i]) begin
      gap = draw_wait(i);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      data_byte <= byte_stream[i];
      do @(posedge clk); while (!in_ready);
      board.take_byte(byte_stream[i]);
    end
    in_valid <= 1'b0;
  endtask

  // Output side: may stall before each transaction, then checks it.
  task automatic sink_units();
    int gap;
    int idx;
    idx = 0;
    forever begin
      gap = draw_wait(idx + 16);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.match_unit(code_unit, is_terminator, last_of_run);
      idx++;
    end
  endtask

  initial begin
    board = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    out_ready <= 1'b0;
    build_stream();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    fork
      sink_units();
    join_none
    send_bytes();
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d units never arrived", board.pending()));
    if (board.mismatch_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/u8u16_pkg.sv
hdl/u8u16_front.sv
hdl/u8u16_fifo.sv
hdl/u8u16_back.sv
hdl/utf8_to_utf16_transcoder.sv
tb/tb.sv
